/* sv/f2nq_pkg.sv */
// Shared types and constants of the frequency-to-note quantiser.
`default_nettype none
package f2nq_pkg;

    // Field widths
    localparam int FREQ_W  = 32;
    localparam int MIDI_W  = 10;
    localparam int PC_W    = 4;
    localparam int OCT_W   = 7;
    localparam int CENTS_W = 14;

    // Log2 format: exponent bits above LOG_FRAC_BITS fraction bits
    localparam int LOG_FRAC_BITS_DEF = 24;
    localparam int EXP_W             = 5;
    localparam int MANT_W            = 32;

    localparam logic [FREQ_W-1:0] DEFAULT_REF = 32'd28835840;

    localparam int A4_NOTE      = 69;
    localparam int NOTES        = 12;
    localparam int CENTS_SCALE  = 10000;
    localparam int CENTS_MAX    = 4999;
    localparam int DIV12_RECIP  = 683;
    localparam int DIV12_SHIFT  = 13;
    localparam int DIV12_PROD_W = 20;
    localparam int QUOT_W       = 6;

    // Mantissas of both lanes travelling down the cell chain
    typedef struct packed {
        logic              ok;
        logic [MANT_W-1:0] mf;
        logic [MANT_W-1:0] mr;
    } t_mant;

endpackage
`default_nettype wire

/* sv/f2nq_norm.sv */
// Front stage: reference selection, range check and leading-one normalisation.
`default_nettype none
module f2nq_norm #(
    parameter int ACC_W = f2nq_pkg::EXP_W + f2nq_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [f2nq_pkg::FREQ_W-1:0] i_frequency,
    input  logic [f2nq_pkg::FREQ_W-1:0] i_ref,
    output logic                        o_valid,
    input  logic                        i_ready,
    output f2nq_pkg::t_mant             o_mant,
    output logic [ACC_W-1:0]            o_acc_f,
    output logic [ACC_W-1:0]            o_acc_r
);
    import f2nq_pkg::*;

    function automatic logic [EXP_W-1:0] lead_one(input logic [FREQ_W-1:0] x);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < FREQ_W; i++) begin
            if (x[i]) begin
                e = EXP_W'(i);
            end
        end
        return e;
    endfunction

    logic                r_vld;
    t_mant               r_mant;
    logic [ACC_W-1:0]    r_acc_f;
    logic [ACC_W-1:0]    r_acc_r;
    logic [FREQ_W-1:0]   ref_sel;
    logic [EXP_W-1:0]    e_f;
    logic [EXP_W-1:0]    e_r;
    t_mant               n_mant;

    assign ref_sel = (i_ref == '0) ? DEFAULT_REF : i_ref;
    assign e_f     = lead_one(i_frequency);
    assign e_r     = lead_one(ref_sel);

    always_comb begin
        n_mant.ok = (i_frequency[FREQ_W-1:16] != '0);
        n_mant.mf = i_frequency << (EXP_W'(FREQ_W - 1) - e_f);
        n_mant.mr = ref_sel << (EXP_W'(FREQ_W - 1) - e_r);
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_mant  <= n_mant;
            r_acc_f <= ACC_W'(e_f);
            r_acc_r <= ACC_W'(e_r);
        end
    end

    assign o_valid = r_vld;
    assign o_mant  = r_mant;
    assign o_acc_f = r_acc_f;
    assign o_acc_r = r_acc_r;

endmodule
`default_nettype wire

/* sv/f2nq_log_cell.sv */
// One log2 cell: squares both mantissas and appends one fraction bit to each lane.
`default_nettype none
module f2nq_log_cell #(
    parameter int ACC_W = f2nq_pkg::EXP_W + f2nq_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  f2nq_pkg::t_mant  i_mant,
    input  logic [ACC_W-1:0] i_acc_f,
    input  logic [ACC_W-1:0] i_acc_r,
    output logic             o_valid,
    input  logic             i_ready,
    output f2nq_pkg::t_mant  o_mant,
    output logic [ACC_W-1:0] o_acc_f,
    output logic [ACC_W-1:0] o_acc_r
);
    import f2nq_pkg::*;

    // Square a Q1.31 mantissa; return the fraction bit above the renormalised mantissa
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
        t  = sq[2*MANT_W-1:MANT_W-1];
        return t[MANT_W] ? {1'b1, t[MANT_W:1]} : {1'b0, t[MANT_W-1:0]};
    endfunction

    logic              r_vld;
    t_mant             r_mant;
    logic [ACC_W-1:0]  r_acc_f;
    logic [ACC_W-1:0]  r_acc_r;
    logic [MANT_W:0]   step_f;
    logic [MANT_W:0]   step_r;

    assign step_f  = sq_step(i_mant.mf);
    assign step_r  = sq_step(i_mant.mr);
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_mant.ok <= i_mant.ok;
            r_mant.mf <= step_f[MANT_W-1:0];
            r_mant.mr <= step_r[MANT_W-1:0];
            r_acc_f   <= {i_acc_f[ACC_W-2:0], step_f[MANT_W]};
            r_acc_r   <= {i_acc_r[ACC_W-2:0], step_r[MANT_W]};
        end
    end

    assign o_valid = r_vld;
    assign o_mant  = r_mant;
    assign o_acc_f = r_acc_f;
    assign o_acc_r = r_acc_r;

endmodule
`default_nettype wire

/* sv/f2nq_post.sv */
// Back end: note value, rounding, cents scaling, octave split and output register.
`default_nettype none
module f2nq_post #(
    parameter int LOG_FRAC_BITS = f2nq_pkg::LOG_FRAC_BITS_DEF,
    parameter int ACC_W         = f2nq_pkg::EXP_W + f2nq_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_ok,
    input  logic [ACC_W-1:0]                    i_acc_f,
    input  logic [ACC_W-1:0]                    i_acc_r,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_note_valid,
    output logic signed [f2nq_pkg::MIDI_W-1:0]  o_midi_number,
    output logic [f2nq_pkg::PC_W-1:0]           o_pitch_class,
    output logic signed [f2nq_pkg::OCT_W-1:0]   o_octave_number,
    output logic signed [f2nq_pkg::CENTS_W-1:0] o_cents_offset
);
    import f2nq_pkg::*;

    localparam int NST  = 6;
    localparam int L    = LOG_FRAC_BITS;
    localparam int DW   = ACC_W + 1;
    localparam int VW   = L + 10;
    localparam int PW   = L + CENTS_W;
    localparam logic [VW-1:0] C_BASE = VW'(A4_NOTE) << L;
    localparam logic [L-1:0]  HALF_L = L'(1) << (L - 1);

    logic [NST-1:0] r_vld;
    logic [NST-2:0] r_ok;
    logic [NST:0]   rdy;

    // Elastic control: a stage takes a word when it is empty or its successor moves
    always_comb begin
        rdy[NST] = i_ready;
        for (int k = 0; k < NST; k++) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_ok[0] <= i_ok;
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (rdy[k]) begin
                r_ok[k] <= r_ok[k-1];
            end
        end
    end

    // Stage 1: log difference
    logic [DW-1:0] r_diff;
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_diff <= {1'b0, i_acc_f} - {1'b0, i_acc_r};
        end
    end

    // Stage 2: v = 69 + 12 * diff
    logic [VW-1:0] dx;
    logic [VW-1:0] r_v;
    assign dx = {{(VW-DW){r_diff[DW-1]}}, r_diff};
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_v <= (dx << 3) + (dx << 2) + C_BASE;
        end
    end

    // Stage 3: sign and magnitude
    logic          r_sign3;
    logic [VW-1:0] r_mag;
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_sign3 <= r_v[VW-1];
            r_mag   <= r_v[VW-1] ? (~r_v + VW'(1)) : r_v;
        end
    end

    // Stage 4: round half away from zero, residue magnitude and sign
    logic [L-1:0]      frac;
    logic              up;
    logic              r_sign4;
    logic              r_rneg4;
    logic [MIDI_W-1:0] r_mmag4;
    logic [L-1:0]      r_rmag;
    assign frac = r_mag[L-1:0];
    assign up   = frac[L-1];
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_sign4 <= r_sign3;
            r_rneg4 <= r_sign3 ^ up;
            r_mmag4 <= r_mag[VW-1:L] + MIDI_W'(up);
            r_rmag  <= up ? (~frac + L'(1)) : frac;
        end
    end

    // Stage 5: cents product and divide by twelve via reciprocal
    logic [DIV12_PROD_W-1:0] qprod;
    logic                    r_sign5;
    logic                    r_rneg5;
    logic [MIDI_W-1:0]       r_mmag5;
    logic [PW-1:0]           r_prod;
    logic [QUOT_W-1:0]       r_quot;
    assign qprod = DIV12_PROD_W'(r_mmag4) * DIV12_PROD_W'(DIV12_RECIP);
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_sign5 <= r_sign4;
            r_rneg5 <= r_rneg4;
            r_mmag5 <= r_mmag4;
            r_prod  <= PW'(r_rmag) * PW'(CENTS_SCALE);
            r_quot  <= qprod[DIV12_SHIFT +: QUOT_W];
        end
    end

    // Stage 6: output register
    logic [PW:0]          csum;
    logic [CENTS_W:0]     cmag;
    logic [CENTS_W-1:0]   cclamp;
    logic [MIDI_W-1:0]    rem_w;
    logic [PC_W-1:0]      rem;
    logic [PC_W-1:0]      pc;
    logic [OCT_W-1:0]     qs;
    logic                 r_nv;
    logic [MIDI_W-1:0]    r_midi;
    logic [PC_W-1:0]      r_pc;
    logic [OCT_W-1:0]     r_oct;
    logic [CENTS_W-1:0]   r_cents;

    assign csum   = (PW+1)'(r_prod) + (PW+1)'(HALF_L);
    assign cmag   = csum[PW:L];
    assign cclamp = (cmag > (CENTS_W+1)'(CENTS_MAX)) ? CENTS_W'(CENTS_MAX)
                                                     : cmag[CENTS_W-1:0];
    assign rem_w  = r_mmag5 - MIDI_W'(r_quot * NOTES);
    assign rem    = rem_w[PC_W-1:0];
    assign pc     = (!r_sign5 || rem == '0) ? rem : PC_W'(NOTES) - rem;
    assign qs     = r_sign5 ? -OCT_W'(r_quot) : OCT_W'(r_quot);

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_nv    <= r_ok[4];
            r_midi  <= r_ok[4] ? (r_sign5 ? -r_mmag5 : r_mmag5) : '0;
            r_pc    <= r_ok[4] ? pc : '0;
            r_oct   <= r_ok[4] ? (qs - OCT_W'(1)) : '0;
            r_cents <= r_ok[4] ? (r_rneg5 ? -cclamp : cclamp) : '0;
        end
    end

    assign o_valid         = r_vld[NST-1];
    assign o_note_valid    = r_nv;
    assign o_midi_number   = r_midi;
    assign o_pitch_class   = r_pc;
    assign o_octave_number = r_oct;
    assign o_cents_offset  = r_cents;

endmodule
`default_nettype wire

/* sv/frequency_to_note_quantizer_top.sv */
// Top level of the frequency-to-note quantiser: register, normaliser, log2 cell row, back end.
//
//  Channel   Direction  Handshake                     Word
//  -------   ---------  ----------------------------  -------------------------------------
//  cfg       in         i_cfg_valid / o_cfg_ready     i_cfg_concert_a_ref (Q16.16 Hz)
//  input     in         i_valid / o_ready             i_frequency (Q16.16 Hz)
//  result    out        o_valid / i_ready             note_valid, midi, pitch, octave, cents
//
// One word enters per cycle while no held result backs up the stages.
// The depth is set by the row of log2 cells, one squaring of each mantissa per fraction bit.
// Every stage is elastic: a held result blocks only the stages behind it, and empty
// stages keep accepting words. Reset clears all valid flags and loads 440 Hz as reference.
`default_nettype none
module frequency_to_note_quantizer_top #(
    parameter int LOG_FRAC_BITS = f2nq_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [f2nq_pkg::FREQ_W-1:0]         i_cfg_concert_a_ref,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [f2nq_pkg::FREQ_W-1:0]         i_frequency,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_note_valid,
    output logic signed [f2nq_pkg::MIDI_W-1:0]  o_midi_number,
    output logic [f2nq_pkg::PC_W-1:0]           o_pitch_class,
    output logic signed [f2nq_pkg::OCT_W-1:0]   o_octave_number,
    output logic signed [f2nq_pkg::CENTS_W-1:0] o_cents_offset
);
    import f2nq_pkg::*;

    localparam int ACC_W = EXP_W + LOG_FRAC_BITS;

    logic [FREQ_W-1:0] r_ref;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= DEFAULT_REF;
        end else if (i_cfg_valid) begin
            r_ref <= i_cfg_concert_a_ref;
        end
    end

    logic             vld   [LOG_FRAC_BITS+1];
    logic             rdy   [LOG_FRAC_BITS+1];
    t_mant            mant  [LOG_FRAC_BITS+1];
    logic [ACC_W-1:0] acc_f [LOG_FRAC_BITS+1];
    logic [ACC_W-1:0] acc_r [LOG_FRAC_BITS+1];

    f2nq_norm #(
        .ACC_W(ACC_W)
    ) u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_frequency(i_frequency),
        .i_ref      (r_ref),
        .o_valid    (vld[0]),
        .i_ready    (rdy[0]),
        .o_mant     (mant[0]),
        .o_acc_f    (acc_f[0]),
        .o_acc_r    (acc_r[0])
    );

    for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_cell
        f2nq_log_cell #(
            .ACC_W(ACC_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(vld[k]),
            .o_ready(rdy[k]),
            .i_mant (mant[k]),
            .i_acc_f(acc_f[k]),
            .i_acc_r(acc_r[k]),
            .o_valid(vld[k+1]),
            .i_ready(rdy[k+1]),
            .o_mant (mant[k+1]),
            .o_acc_f(acc_f[k+1]),
            .o_acc_r(acc_r[k+1])
        );
    end

    f2nq_post #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS),
        .ACC_W        (ACC_W)
    ) u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (vld[LOG_FRAC_BITS]),
        .o_ready        (rdy[LOG_FRAC_BITS]),
        .i_ok           (mant[LOG_FRAC_BITS].ok),
        .i_acc_f        (acc_f[LOG_FRAC_BITS]),
        .i_acc_r        (acc_r[LOG_FRAC_BITS]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_note_valid   (o_note_valid),
        .o_midi_number  (o_midi_number),
        .o_pitch_class  (o_pitch_class),
        .o_octave_number(o_octave_number),
        .o_cents_offset (o_cents_offset)
    );

endmodule
`default_nettype wire

/* sv/f2nq_checker.sv */
// Port-level checks on the result channel of the quantiser, bound to the top level.
`default_nettype none
module f2nq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_note_valid,
    input logic signed [f2nq_pkg::MIDI_W-1:0]  o_midi_number,
    input logic [f2nq_pkg::PC_W-1:0]           o_pitch_class,
    input logic signed [f2nq_pkg::OCT_W-1:0]   o_octave_number,
    input logic signed [f2nq_pkg::CENTS_W-1:0] o_cents_offset
);
    import f2nq_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_note_valid) && $stable(o_midi_number)
            && $stable(o_pitch_class) && $stable(o_octave_number) && $stable(o_cents_offset))
        else $error("stalled result word changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_note_valid |-> o_midi_number == '0 && o_pitch_class == '0
            && o_octave_number == '0 && o_cents_offset == '0)
        else $error("sub-hertz result has nonzero fields");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_note_valid |-> int'(o_pitch_class) < NOTES
            && int'(o_cents_offset) <= CENTS_MAX && int'(o_cents_offset) >= -CENTS_MAX)
        else $error("pitch class or cents out of range");

    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_note_valid && !o_midi_number[MIDI_W-1] |->
            int'(o_midi_number) == NOTES * (int'(o_octave_number) + 1) + int'(o_pitch_class))
        else $error("octave and pitch class disagree with note number");

endmodule

bind frequency_to_note_quantizer_top f2nq_checker u_f2nq_checker (.*);
`default_nettype wire

/* tb/f2nq_scoreboard_pkg.sv */
// Bit-exact note predictor and result scoreboard for the frequency-to-note quantiser bench.
package f2nq_scoreboard_pkg;
    import f2nq_pkg::*;

    localparam int                LOG_FRAC = LOG_FRAC_BITS_DEF;
    localparam logic [FREQ_W-1:0] ONE_HZ   = 32'h0001_0000;

    typedef struct packed {
        logic               note_valid;
        logic [MIDI_W-1:0]  midi;
        logic [PC_W-1:0]    pitch;
        logic [OCT_W-1:0]   octave;
        logic [CENTS_W-1:0] cents;
    } t_note_word;

    typedef struct {
        logic [FREQ_W-1:0] freq;
        t_note_word        word;
    } t_note_entry;

    class note_scoreboard;
        t_note_entry       pending_notes[$];
        logic [FREQ_W-1:0] concert_ref = DEFAULT_REF;
        int                errors      = 0;

        // Integer part is the top set bit, then one fraction bit per squaring of the mantissa
        function longint log2_fixed(logic [FREQ_W-1:0] x);
            int          e;
            logic [63:0] m;
            longint      acc;
            e = FREQ_W - 1;
            while (e > 0 && !x[e])
                e--;
            m   = 64'(x) << (31 - e);
            acc = longint'(e);
            for (int i = 0; i < LOG_FRAC; i++) begin
                m   = (m * m) >> 31;
                acc = acc << 1;
                if (m >= 64'h1_0000_0000) begin
                    acc = acc | 64'd1;
                    m   = m >> 1;
                end
            end
            return acc;
        endfunction

        function t_note_word predict_note(logic [FREQ_W-1:0] freq);
            t_note_word        w;
            logic [FREQ_W-1:0] a_ref;
            longint            one, half, diff, v, r, cents;
            int                midi, pc, oct;
            w = '0;
            if (freq < ONE_HZ)
                return w;
            a_ref = (concert_ref != '0) ? concert_ref : DEFAULT_REF;
            one   = longint'(1) << LOG_FRAC;
            half  = one >>> 1;
            diff  = log2_fixed(freq) - log2_fixed(a_ref);
            v     = longint'(A4_NOTE) * one + longint'(NOTES) * diff;
            // Round half away from zero
            if (v >= 0)
                midi = int'((v + half) >>> LOG_FRAC);
            else
                midi = -int'(((-v) + half) >>> LOG_FRAC);
            pc  = ((midi % NOTES) + NOTES) % NOTES;
            oct = midi / NOTES - 1;
            r   = v - longint'(midi) * one;
            if (r >= 0)
                cents = (r * CENTS_SCALE + half) >>> LOG_FRAC;
            else
                cents = -(((-r) * CENTS_SCALE + half) >>> LOG_FRAC);
            if (cents > CENTS_MAX)
                cents = CENTS_MAX;
            if (cents < -CENTS_MAX)
                cents = -CENTS_MAX;
            w.note_valid = 1'b1;
            w.midi       = MIDI_W'(midi);
            w.pitch      = PC_W'(pc);
            w.octave     = OCT_W'(oct);
            w.cents      = CENTS_W'(cents);
            return w;
        endfunction

        function void note_frequency(logic [FREQ_W-1:0] freq);
            t_note_entry e;
            e.freq = freq;
            e.word = predict_note(freq);
            pending_notes.push_back(e);
        endfunction

        function int pending();
            return pending_notes.size();
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_note(t_note_word got);
            t_note_entry e;
            if (pending_notes.size() == 0) begin
                report("result word with no frequency outstanding");
                return;
            end
            e = pending_notes.pop_front();
            if (got.note_valid !== e.word.note_valid)
                report($sformatf("freq %08h note_valid got %0b expected %0b",
                                 e.freq, got.note_valid, e.word.note_valid));
            if (got.midi !== e.word.midi)
                report($sformatf("freq %08h midi got %0d expected %0d",
                                 e.freq, $signed(got.midi), $signed(e.word.midi)));
            if (got.pitch !== e.word.pitch)
                report($sformatf("freq %08h pitch got %0d expected %0d",
                                 e.freq, got.pitch, e.word.pitch));
            if (got.octave !== e.word.octave)
                report($sformatf("freq %08h octave got %0d expected %0d",
                                 e.freq, $signed(got.octave), $signed(e.word.octave)));
            if (got.cents !== e.word.cents)
                report($sformatf("freq %08h cents got %0d expected %0d",
                                 e.freq, $signed(got.cents), $signed(e.word.cents)));
        endtask
    endclass

endpackage

/* tb/frequency_to_note_quantizer_top_tb.sv */
// Top-level bench of the frequency-to-note quantiser: stimulus, back-pressure and checking.
module frequency_to_note_quantizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import f2nq_pkg::*;
    import f2nq_scoreboard_pkg::*;

    localparam int LATENCY      = LOG_FRAC_BITS_DEF + 7;
    localparam int GAP_HEAVY    = 88;
    localparam int GAP_LIGHT    = 21;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 160;
    localparam int DIRECTED_N   = 20;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam logic [FREQ_W-1:0] DIRECTED_FREQS [DIRECTED_N] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
        32'h0001_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'd28835840,  32'd57671680,  32'd14417920,  32'd17146184,
        32'd29680770,  32'd29680771,  32'hAAAA_AAAA, 32'h5555_5555,
        32'd1802240,   32'd1310720,   32'd1310720000, 32'd30550476
    };

    logic                    i_clk               = 1'b0;
    logic                    i_rst_n             = 1'b0;
    logic                    i_cfg_valid         = 1'b0;
    logic [FREQ_W-1:0]       i_cfg_concert_a_ref = '0;
    logic                    i_valid             = 1'b0;
    logic [FREQ_W-1:0]       i_frequency         = '0;
    logic                    i_ready             = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_note_valid;
    logic signed [MIDI_W-1:0]  o_midi_number;
    logic [PC_W-1:0]           o_pitch_class;
    logic signed [OCT_W-1:0]   o_octave_number;
    logic signed [CENTS_W-1:0] o_cents_offset;

    t_idle_mode     idle_mode = IDLE_NONE;
    note_scoreboard sb        = new();

    frequency_to_note_quantizer_top #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS_DEF)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_concert_a_ref(i_cfg_concert_a_ref),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_frequency        (i_frequency),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_note_valid       (o_note_valid),
        .o_midi_number      (o_midi_number),
        .o_pitch_class      (o_pitch_class),
        .o_octave_number    (o_octave_number),
        .o_cents_offset     (o_cents_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: i_ready <= ($urandom_range(99) >= GAP_HEAVY);
            IDLE_BOTH: i_ready <= ($urandom_range(99) >= GAP_LIGHT);
            default:   i_ready <= 1'b1;
        endcase
    end

    // Watch all three handshakes at the edge that completes them
    always @(posedge i_clk) begin
        t_note_word got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.concert_ref = i_cfg_concert_a_ref;
            if (i_valid && o_ready)
                sb.note_frequency(i_frequency);
            if (o_valid && i_ready) begin
                got.note_valid = o_note_valid;
                got.midi       = o_midi_number;
                got.pitch      = o_pitch_class;
                got.octave     = o_octave_number;
                got.cents      = o_cents_offset;
                sb.check_note(got);
            end
        end
    end

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < GAP_HEAVY;
            IDLE_BOTH: return $urandom_range(99) < GAP_LIGHT;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] random_freq();
        int unsigned       pick;
        logic [FREQ_W-1:0] a_ref;
        pick  = $urandom_range(99);
        a_ref = (sb.concert_ref != '0) ? sb.concert_ref : DEFAULT_REF;
        if (pick < 8)
            return $urandom_range(32'h0000_FFFF, 0);
        else if (pick < 16)
            return ONE_HZ + $urandom_range(255, 0);
        else if (pick < 22)
            return a_ref >> $urandom_range(8, 0);
        else if (pick < 50)
            return $urandom;
        else
            return $urandom_range(32'd1310720000, 32'd1310720);
    endfunction

    task automatic send_freq(input logic [FREQ_W-1:0] f);
        while (sender_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_frequency <= f;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // Let the clock advance first so the last accepted word is already counted as outstanding
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_ref(input logic [FREQ_W-1:0] val);
        i_cfg_valid         <= 1'b1;
        i_cfg_concert_a_ref <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [FREQ_W-1:0] phase_refs [PHASES];
        phase_refs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
                       32'h0001_0000, 32'h0000_0000, 32'd28311552,  32'h0000_0000,
                       DEFAULT_REF};
        phase_refs[5] = $urandom;
        phase_refs[7] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset reference
        foreach (DIRECTED_FREQS[k])
            send_freq(DIRECTED_FREQS[k]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_ref(phase_refs[p]);
            idle_mode = t_idle_mode'(p % 4);
            // Hit both ends of the note range under each reference
            send_freq(32'hFFFF_FFFF);
            send_freq(ONE_HZ);
            repeat (PHASE_ITEMS)
                send_freq(random_freq());
        end

        drain();
        idle_mode = IDLE_NONE;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
sv/f2nq_pkg.sv
sv/f2nq_norm.sv
sv/f2nq_log_cell.sv
sv/f2nq_post.sv
sv/frequency_to_note_quantizer_top.sv
sv/f2nq_checker.sv
tb/f2nq_scoreboard_pkg.sv
tb/frequency_to_note_quantizer_top_tb.sv
